// ----- src/extent_offset_translator_unit_defines.svh -----
// Assertion macros for the extent offset translator checker.
`ifndef EXTENT_OFFSET_TRANSLATOR_UNIT_DEFINES_SVH
`define EXTENT_OFFSET_TRANSLATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EOT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EOT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/eot_pkg.sv -----
// Shared types and constants of the extent offset translator.
`timescale 1ns / 1ps
`default_nettype none
package eot_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_QUERY = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_SEALED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_WALK = 2'd2,
        S_DONE = 2'd3
    } t_state;

    // Search state carried by a query as it walks the cell row
    typedef struct packed {
        logic [63:0] offset;
        logic        found;
        logic [63:0] best_lg;
        logic [63:0] best_dl;
        logic        have_next;
        logic [63:0] next_lg;
    } t_token;

    // Entry write request; delta is physical minus logical start
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [63:0]      logical;
        logic [63:0]      delta;
    } t_entry_wr;

endpackage
`default_nettype wire

// ----- src/eot_cell.sv -----
// One table cell: holds an extent entry and updates a passing query.
`timescale 1ns / 1ps
`default_nettype none
module eot_cell
    import eot_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_entry_valid,
    input  wire logic        i_we,
    input  wire logic [63:0] i_wr_lg,
    input  wire logic [63:0] i_wr_dl,
    input  wire logic        i_vld,
    input  wire t_token      i_tok,
    output logic             o_vld,
    output t_token           o_tok
);

    logic [63:0] r_lg;
    logic [63:0] r_dl;
    logic        r_vld;
    t_token      r_tok;
    t_token      n_tok;
    logic        w_le;
    logic        w_take_best;
    logic        w_take_next;

    // Store the entry when this cell is addressed
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_lg <= i_wr_lg;
            r_dl <= i_wr_dl;
        end
    end

    // Fold this entry into the query search state
    always_comb begin
        w_le        = (r_lg <= i_tok.offset);
        w_take_best = i_entry_valid && w_le &&
                      (!i_tok.found || (r_lg >= i_tok.best_lg));
        w_take_next = i_entry_valid && !w_le &&
                      (!i_tok.have_next || (r_lg < i_tok.next_lg));
        n_tok = i_tok;
        if (w_take_best) begin
            n_tok.found   = 1'b1;
            n_tok.best_lg = r_lg;
            n_tok.best_dl = r_dl;
        end
        if (w_take_next) begin
            n_tok.have_next = 1'b1;
            n_tok.next_lg   = r_lg;
        end
    end

    // Hand the query to the neighbor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
    end

    assign o_vld = r_vld;
    assign o_tok = r_tok;

endmodule
`default_nettype wire

// ----- src/eot_chain.sv -----
// Row of table cells with write decode and entry valid derivation.
`timescale 1ns / 1ps
`default_nettype none
module eot_chain
    import eot_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [CNT_W-1:0] i_count,
    input  wire t_entry_wr        i_wr,
    input  wire logic             i_vld,
    input  wire t_token           i_tok,
    output logic                  o_vld,
    output t_token                o_tok
);

    logic   w_vld [TABLE_ENTRIES+1];
    t_token w_tok [TABLE_ENTRIES+1];

    assign w_vld[0] = i_vld;
    assign w_tok[0] = i_tok;

    // Build the row; cell i is live while i is below the fill count
    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
        eot_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_entry_valid (i_count > CNT_W'(i)),
            .i_we          (i_wr.en && (i_wr.idx == IDX_W'(i))),
            .i_wr_lg       (i_wr.logical),
            .i_wr_dl       (i_wr.delta),
            .i_vld         (w_vld[i]),
            .i_tok         (w_tok[i]),
            .o_vld         (w_vld[i+1]),
            .o_tok         (w_tok[i+1])
        );
    end

    assign o_vld = w_vld[TABLE_ENTRIES];
    assign o_tok = w_tok[TABLE_ENTRIES];

endmodule
`default_nettype wire

// ----- src/extent_offset_translator_unit.sv -----
// Flow: an accepted transaction goes to S_EXEC; a query then walks the cell row in
//   S_WALK, one cell per cycle, and any command then waits in S_DONE until the
//   output register is free; add, clear and the unused command skip S_WALK.
// Only one transaction is handled at a time; a result waiting in the output
//   register does not block the next accept.
// Reset: synchronous active low; empties the table, unseals it, clears state.
`timescale 1ns / 1ps
`default_nettype none
module extent_offset_translator_unit
    import eot_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [63:0] logical_offset, [127:64] physical_offset, [191:128] extent_length
    input  wire logic [191:0] s_axis_tdata,
    // [1:0] command
    input  wire logic [1:0]   s_axis_tuser,
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [63:0] translated_address, [127:64] bytes_to_next
    output logic [127:0]      m_axis_tdata,
    // [0] hit, [2:1] status
    output logic [2:0]        m_axis_tuser
);

    t_state           r_state;
    t_state           n_state;
    t_cmd             r_cmd;
    logic [63:0]      r_lg;
    logic [63:0]      r_ph;
    logic [63:0]      r_len;
    logic             r_last;
    logic [CNT_W-1:0] r_count;
    logic [63:0]      r_expected;
    logic             r_sealed;
    logic [63:0]      r_p_addr;
    logic [63:0]      r_p_dist;
    logic             r_p_hit;
    t_status          r_p_status;
    logic             r_m_valid;
    logic [63:0]      r_m_addr;
    logic [63:0]      r_m_dist;
    logic             r_m_hit;
    t_status          r_m_status;

    logic      w_accept;
    logic      w_out_free;
    logic      w_exec;
    logic      w_finish;
    logic      w_load_out;
    logic      w_store;
    logic      w_room;
    t_status   w_exec_status;
    t_entry_wr w_wr;
    logic      w_tok_vld;
    t_token    w_tok_in;
    logic      w_chain_vld;
    t_token    w_chain_tok;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_m_valid || m_axis_tready;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and control strobes
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        w_exec        = 1'b0;
        w_finish      = 1'b0;
        w_load_out    = 1'b0;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                w_exec  = 1'b1;
                n_state = (r_cmd == CMD_QUERY) ? S_WALK : S_DONE;
            end
            S_WALK: begin
                if (w_chain_vld) begin
                    w_finish = 1'b1;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Capture the input transaction
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= t_cmd'(s_axis_tuser);
            r_lg   <= s_axis_tdata[63:0];
            r_ph   <= s_axis_tdata[127:64];
            r_len  <= s_axis_tdata[191:128];
            r_last <= s_axis_tlast;
        end
    end

    // Decide whether an add is stored, dropped or ignored
    always_comb begin
        w_store       = (r_count == '0) || (r_ph != r_expected);
        w_room        = r_count < CNT_W'(TABLE_ENTRIES);
        w_exec_status = ST_OK;
        if (r_cmd == CMD_ADD) begin
            if (r_sealed) begin
                w_exec_status = ST_SEALED;
            end else if (w_store && !w_room) begin
                w_exec_status = ST_FULL;
            end
        end
        w_wr.en      = w_exec && (r_cmd == CMD_ADD) && !r_sealed && w_store && w_room;
        w_wr.idx     = r_count[IDX_W-1:0];
        w_wr.logical = r_lg;
        w_wr.delta   = r_ph - r_lg;
    end

    // Launch a query into the row with an empty search state
    always_comb begin
        w_tok_vld          = w_exec && (r_cmd == CMD_QUERY);
        w_tok_in.offset    = r_lg;
        w_tok_in.found     = 1'b0;
        w_tok_in.best_lg   = '0;
        w_tok_in.best_dl   = '0;
        w_tok_in.have_next = 1'b0;
        w_tok_in.next_lg   = '0;
    end

    eot_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_count (r_count),
        .i_wr    (w_wr),
        .i_vld   (w_tok_vld),
        .i_tok   (w_tok_in),
        .o_vld   (w_chain_vld),
        .o_tok   (w_chain_tok)
    );

    // Update table bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_expected <= '0;
            r_sealed   <= 1'b0;
        end else if (w_exec) begin
            case (r_cmd)
                CMD_CLEAR: begin
                    r_count    <= '0;
                    r_expected <= '0;
                    r_sealed   <= 1'b0;
                end
                CMD_ADD: begin
                    if (!r_sealed) begin
                        if (w_wr.en) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        r_expected <= r_ph + r_len;
                        if (r_last) begin
                            r_sealed <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    // Hold the finished result until the output stage is free
    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_p_addr   <= '0;
            r_p_dist   <= '0;
            r_p_hit    <= 1'b0;
            r_p_status <= w_exec_status;
        end else if (w_finish) begin
            r_p_addr   <= w_chain_tok.found ?
                          (w_chain_tok.best_dl + w_chain_tok.offset) : 64'd0;
            r_p_dist   <= w_chain_tok.have_next ?
                          (w_chain_tok.next_lg - w_chain_tok.offset) : 64'd0;
            r_p_hit    <= w_chain_tok.found;
            r_p_status <= ST_OK;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load_out) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_m_addr   <= r_p_addr;
            r_m_dist   <= r_p_dist;
            r_m_hit    <= r_p_hit;
            r_m_status <= r_p_status;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_m_dist, r_m_addr};
    assign m_axis_tuser  = {r_m_status, r_m_hit};

endmodule
`default_nettype wire

// ----- src/eot_checker.sv -----
// Port-level checks for the extent offset translator and their binding.
`timescale 1ns / 1ps
`default_nettype none
`include "extent_offset_translator_unit_defines.svh"
module eot_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic [191:0] s_axis_tdata,
    input wire logic [1:0]   s_axis_tuser,
    input wire logic         s_axis_tlast,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [127:0] m_axis_tdata,
    input wire logic [2:0]   m_axis_tuser
);

    // A stalled result keeps its contents
    `EOT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // One transaction in work: ready drops right after an accept
    `EOT_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready high after accept")

    // A hit comes only from a query, whose status is ok
    `EOT_ASSERT_NOW(a_hit_status, m_axis_tvalid && m_axis_tuser[0], m_axis_tuser[2:1] == 2'd0, "hit with nonzero status")

    // A miss carries a zero address
    `EOT_ASSERT_NOW(a_miss_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[63:0] == 64'd0, "miss with nonzero address")

endmodule

bind extent_offset_translator_unit eot_checker u_eot_checker (.*);
`default_nettype wire
